// ----- rtl/pfd_pkg.sv -----
// Shared definitions for the filtered-derivative PID block.
// Register index codes and their reset values; no dependencies.
package pfd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgCount = 8;
  localparam int unsigned RstW     = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I_STEP  = 3'd1,
    CFG_GAIN_D_STEP  = 3'd2,
    CFG_FILTER_POLE  = 3'd3,
    CFG_OUT_FLOOR    = 3'd4,
    CFG_OUT_CEILING  = 3'd5,
    CFG_INT_FLOOR    = 3'd6,
    CFG_INT_CEILING  = 3'd7
  } cfg_idx_e;

  // Reset values, sign extended to 64 bits; users truncate to their data width.
  localparam logic [RstW-1:0] CfgReset [CfgCount] = '{
    64'h0000_0000_0002_0000,
    64'h0000_0000_0000_0021,
    64'h0000_0000_0003_9249,
    64'hFFFF_FFFF_FFFF_9249,
    64'h0000_0000_0000_0000,
    64'h0000_0000_00FF_0000,
    64'hFFFF_FFFF_FF01_0000,
    64'h0000_0000_00FF_0000
  };

endpackage

// ----- rtl/pfd_regs.sv -----
// Configuration register file for the filtered-derivative PID block.
// Depends on pfd_pkg for index codes and reset values.
module pfd_regs import pfd_pkg::*; #(
  parameter int unsigned DW = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [DW-1:0]              cfg_data_i,
  output logic signed [DW-1:0]       cfg_o [CfgCount]
);

  logic [DW-1:0] regs_q [CfgCount];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CfgCount; i++) begin
        regs_q[i] <= CfgReset[i][DW-1:0];
      end
    end else if (cfg_valid_i) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < CfgCount; i++) begin
      cfg_o[i] = $signed(regs_q[i]);
    end
  end

endmodule

// ----- rtl/pfd_mulq.sv -----
// Fixed-point multiply: exact product, arithmetic shift by the fraction
// width, saturate to the data width. No dependencies.
module pfd_mulq #(
  parameter int unsigned DW = 32,
  parameter int unsigned FW = 16,
  parameter int unsigned BW = 33
) (
  input  logic signed [DW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [DW-1:0] p_o
);

  localparam int unsigned PW = DW + BW;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;
  logic [PW-DW:0]       hi;

  assign prod    = PW'(a_i) * PW'(b_i);
  assign shifted = prod >>> FW;
  assign hi      = shifted[PW-1:DW-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      p_o = shifted[DW-1:0];
    end else if (hi[PW-DW]) begin
      p_o = $signed({1'b1, {(DW-1){1'b0}}});
    end else begin
      p_o = $signed({1'b0, {(DW-1){1'b1}}});
    end
  end

endmodule

// ----- rtl/pfd_core.sv -----
// Control law for the filtered-derivative PID block: error, integrator,
// derivative filter, output clamp and the four state registers.
// Depends on pfd_pkg and pfd_mulq.
module pfd_core import pfd_pkg::*; #(
  parameter int unsigned DW = 32,
  parameter int unsigned FW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic signed [DW-1:0] target_i,
  input  logic signed [DW-1:0] sensed_i,
  input  logic                 reverse_i,
  input  logic signed [DW-1:0] cfg_i [CfgCount],
  output logic signed [DW-1:0] drive_o
);

  localparam logic signed [DW-1:0] MaxV = $signed({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [DW-1:0] MinV = $signed({1'b1, {(DW-1){1'b0}}});

  logic signed [DW-1:0] integ_q, last_err_q, dterm_q, last_sensed_q;
  logic signed [DW-1:0] integ_d, der_d;

  logic signed [DW:0]   t_x, s_x, err_w, esum, ds;
  logic signed [DW-1:0] err;
  logic signed [DW-1:0] prop, ipart, dpart_a, dpart_b;
  logic signed [DW:0]   isum, int_floor_x, int_ceil_x, dsum;
  logic signed [DW+1:0] dneg, total, out_floor_x, out_ceil_x;
  logic [2:0]           dneg_hi;

  assign t_x   = $signed({target_i[DW-1], target_i});
  assign s_x   = $signed({sensed_i[DW-1], sensed_i});
  assign err_w = reverse_i ? (s_x - t_x) : (t_x - s_x);

  always_comb begin
    if (err_w[DW] == err_w[DW-1]) begin
      err = err_w[DW-1:0];
    end else if (err_w[DW]) begin
      err = MinV;
    end else begin
      err = MaxV;
    end
  end

  assign esum = $signed({err[DW-1], err}) + $signed({last_err_q[DW-1], last_err_q});
  assign ds   = s_x - $signed({last_sensed_q[DW-1], last_sensed_q});

  pfd_mulq #(.DW(DW), .FW(FW), .BW(DW)) u_mul_p (
    .a_i(cfg_i[CFG_GAIN_P]), .b_i(err), .p_o(prop)
  );
  pfd_mulq #(.DW(DW), .FW(FW), .BW(DW + 1)) u_mul_i (
    .a_i(cfg_i[CFG_GAIN_I_STEP]), .b_i(esum), .p_o(ipart)
  );
  pfd_mulq #(.DW(DW), .FW(FW), .BW(DW + 1)) u_mul_d (
    .a_i(cfg_i[CFG_GAIN_D_STEP]), .b_i(ds), .p_o(dpart_a)
  );
  pfd_mulq #(.DW(DW), .FW(FW), .BW(DW)) u_mul_f (
    .a_i(cfg_i[CFG_FILTER_POLE]), .b_i(dterm_q), .p_o(dpart_b)
  );

  assign int_floor_x = $signed({cfg_i[CFG_INT_FLOOR][DW-1], cfg_i[CFG_INT_FLOOR]});
  assign int_ceil_x  = $signed({cfg_i[CFG_INT_CEILING][DW-1], cfg_i[CFG_INT_CEILING]});
  assign isum = $signed({integ_q[DW-1], integ_q}) + $signed({ipart[DW-1], ipart});

  always_comb begin
    if (isum > int_ceil_x) begin
      integ_d = cfg_i[CFG_INT_CEILING];
    end else if (isum < int_floor_x) begin
      integ_d = cfg_i[CFG_INT_FLOOR];
    end else begin
      integ_d = isum[DW-1:0];
    end
  end

  assign dsum    = $signed({dpart_a[DW-1], dpart_a}) + $signed({dpart_b[DW-1], dpart_b});
  assign dneg    = $signed((DW+2)'(0)) - $signed({dsum[DW], dsum});
  assign dneg_hi = dneg[DW+1:DW-1];

  always_comb begin
    if ((&dneg_hi) || !(|dneg_hi)) begin
      der_d = dneg[DW-1:0];
    end else if (dneg_hi[2]) begin
      der_d = MinV;
    end else begin
      der_d = MaxV;
    end
  end

  assign total = $signed({{2{prop[DW-1]}}, prop})
               + $signed({{2{integ_d[DW-1]}}, integ_d})
               + $signed({{2{der_d[DW-1]}}, der_d});
  assign out_floor_x = $signed({{2{cfg_i[CFG_OUT_FLOOR][DW-1]}}, cfg_i[CFG_OUT_FLOOR]});
  assign out_ceil_x  = $signed({{2{cfg_i[CFG_OUT_CEILING][DW-1]}}, cfg_i[CFG_OUT_CEILING]});

  always_comb begin
    if (total > out_ceil_x) begin
      drive_o = cfg_i[CFG_OUT_CEILING];
    end else if (total < out_floor_x) begin
      drive_o = cfg_i[CFG_OUT_FLOOR];
    end else begin
      drive_o = total[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q       <= '0;
      last_err_q    <= '0;
      dterm_q       <= '0;
      last_sensed_q <= '0;
    end else if (step_i) begin
      integ_q       <= integ_d;
      last_err_q    <= err;
      dterm_q       <= der_d;
      last_sensed_q <= sensed_i;
    end
  end

endmodule

// ----- rtl/pid_filtered_derivative.sv -----
// Top level of the PID controller with band-limited derivative on the measurement.
// Depends on pfd_pkg, pfd_regs and pfd_core.
//
// Usage:
//   s_axis carries one sample per transaction: setpoint and measurement in
//   tdata, the reverse-acting flag in tuser. m_axis returns one clamped drive
//   value per sample, in order. cfg_* writes one of eight coefficient and limit
//   registers per transaction; cfg_ready_o is always high. Write registers only
//   while no sample is in flight.
//   Path: an accepted sample passes through two registers, the input register
//   and then the result register, before its drive value appears on m_axis.
//   Throughput: one sample per cycle while m_axis is not stalled; the control law is a single combinational
//   pass of four parallel multipliers, adds and clamps between the two registers.
//   Stall: when m_axis_tready is low the result is held, the input register
//   holds its sample and s_axis_tready drops once both are full.
//   Reset: registers take their default coefficients and limits, the
//   integrator, derivative and history terms clear, and both channels empty.
module pid_filtered_derivative import pfd_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [DW-1:0] target, [2DW-1:DW] sensed, zero padding above
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // [0] reverse_acting
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [DW-1:0] drive, zero padding above
  output logic [((DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]                    cfg_index_i,
  input  logic [DATA_WIDTH-1:0]                 cfg_data_i
);

  localparam int unsigned OutW = ((DATA_WIDTH + 7) / 8) * 8;

  logic                         in_valid_q, in_valid_d;
  logic signed [DATA_WIDTH-1:0] target_q, sensed_q;
  logic                         reverse_q;
  logic                         out_valid_q, out_valid_d;
  logic signed [DATA_WIDTH-1:0] drive_q, drive_d;
  logic                         step, in_take;
  logic signed [DATA_WIDTH-1:0] cfg [CfgCount];

  pfd_regs #(.DW(DATA_WIDTH)) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  pfd_core #(.DW(DATA_WIDTH), .FW(FRAC_BITS)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .target_i  (target_q),
    .sensed_i  (sensed_q),
    .reverse_i (reverse_q),
    .cfg_i     (cfg),
    .drive_o   (drive_d)
  );

  always_comb begin
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      target_q  <= $signed(s_axis_tdata[DATA_WIDTH-1:0]);
      sensed_q  <= $signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
      reverse_q <= s_axis_tuser;
    end
    if (step) begin
      drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(unsigned'(drive_q));

endmodule

// ----- sim/pid_law_monitor.sv -----
// Monitor for pid_filtered_derivative: watches the sample, result and register channels,
// predicts each drive value from its own copy of the controller state and compares.
// Depends on pfd_pkg for register indexes and reset values.
module pid_law_monitor import pfd_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  input  logic                              s_ready_i,
  // [DW-1:0] target, [2DW-1:DW] sensed, zero padding above
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_data_i,
  // [0] reverse_acting
  input  logic                              s_user_i,
  input  logic                              m_valid_i,
  input  logic                              m_ready_i,
  // [DW-1:0] drive, zero padding above
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]   m_data_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [CfgIdxW-1:0]                cfg_index_i,
  input  logic [DATA_WIDTH-1:0]             cfg_data_i,
  output int unsigned                       failures_o,
  output int unsigned                       pending_o,
  output int unsigned                       checked_o
);

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [127:0]          wide_t;

  localparam wide_t WordMax = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam wide_t WordMin = -WordMax - 1;

  word_t coef [CfgCount];
  word_t integral_q;
  word_t error_q;
  word_t derivative_q;
  word_t sensed_q;
  word_t expected_drive [$];

  function automatic word_t clip_word(wide_t x);
    word_t r;
    if (x > WordMax) begin
      r = WordMax[DATA_WIDTH-1:0];
    end else if (x < WordMin) begin
      r = WordMin[DATA_WIDTH-1:0];
    end else begin
      r = x[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic word_t scaled_product(wide_t a, wide_t b);
    wide_t p;
    p = (a * b) >>> FRAC_BITS;
    return clip_word(p);
  endfunction

  function automatic wide_t limit_top_first(wide_t x, wide_t lo, wide_t hi);
    wide_t r;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // advance the controller state by one sample and return the drive it yields
  function automatic word_t next_drive(word_t tgt, word_t meas, logic rev);
    wide_t w_tgt, w_meas, w_err, w_last, w_sum, w_der, w_total;
    word_t err;
    w_tgt  = tgt;
    w_meas = meas;
    w_err  = rev ? w_meas - w_tgt : w_tgt - w_meas;
    err    = clip_word(w_err);
    w_err  = err;
    w_last = error_q;
    w_sum  = integral_q;
    w_sum  = w_sum + scaled_product(coef[CFG_GAIN_I_STEP], w_err + w_last);
    w_sum  = limit_top_first(w_sum, coef[CFG_INT_FLOOR], coef[CFG_INT_CEILING]);
    integral_q = w_sum[DATA_WIDTH-1:0];
    w_last = sensed_q;
    w_der  = scaled_product(coef[CFG_GAIN_D_STEP], w_meas - w_last);
    w_der  = w_der + scaled_product(coef[CFG_FILTER_POLE], derivative_q);
    derivative_q = clip_word(-w_der);
    w_total = scaled_product(coef[CFG_GAIN_P], w_err);
    w_total = w_total + integral_q;
    w_total = w_total + derivative_q;
    w_total = limit_top_first(w_total, coef[CFG_OUT_FLOOR], coef[CFG_OUT_CEILING]);
    error_q  = err;
    sensed_q = meas;
    return w_total[DATA_WIDTH-1:0];
  endfunction

  task automatic report(input string msg);
    $display("[%0t] drive check: %s", $time, msg);
    failures_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CfgCount; i++) coef[i] = CfgReset[i][DATA_WIDTH-1:0];
      integral_q   = '0;
      error_q      = '0;
      derivative_q = '0;
      sensed_q     = '0;
      expected_drive.delete();
      failures_o = 0;
      checked_o  = 0;
      pending_o  = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (expected_drive.size() == 0) begin
          report($sformatf("drive %h with no sample outstanding", m_data_i[DATA_WIDTH-1:0]));
        end else begin
          want = expected_drive.pop_front();
          checked_o++;
          if (m_data_i[DATA_WIDTH-1:0] !== want) begin
            report($sformatf("drive %h, predicted %h", m_data_i[DATA_WIDTH-1:0], want));
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        expected_drive.push_back(next_drive(s_data_i[DATA_WIDTH-1:0],
                                            s_data_i[2*DATA_WIDTH-1:DATA_WIDTH], s_user_i));
      end
      if (cfg_valid_i && cfg_ready_i) coef[cfg_index_i] = cfg_data_i;
      pending_o = unsigned'(expected_drive.size());
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the pid_filtered_derivative simulation: clock, reset, sample and register stimulus,
// random stalls on both stream sides, idle watchdog and verdict.
// Depends on pfd_pkg, pid_filtered_derivative and pid_law_monitor.
module testbench;
  import pfd_pkg::*;

  localparam int unsigned DataW        = 32;
  localparam int unsigned FracW        = 16;
  localparam int unsigned SampleW      = ((2*DataW+7)/8)*8;
  localparam int unsigned ResultW      = ((DataW+7)/8)*8;
  localparam int unsigned IdleLimit    = 500;
  localparam int unsigned SetCount     = 8;
  localparam int unsigned RandomPerSet = 72;

  typedef logic [DataW-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(DataW-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DataW-1){1'b0}}};

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ResultW-1:0] m_axis_tdata;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  cfg_idx_e           cfg_index_i   = CFG_GAIN_P;
  word_t              cfg_data_i    = '0;

  bit          steady       = 1'b0;
  int unsigned samples_sent = 0;
  int unsigned writes_done  = 0;
  int unsigned sets_run     = 0;
  int unsigned failures;
  int unsigned pending;
  int unsigned checked;

  always #5 clk_i = ~clk_i;

  pid_filtered_derivative #(
    .DATA_WIDTH(DataW),
    .FRAC_BITS (FracW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  pid_law_monitor #(
    .DATA_WIDTH(DataW),
    .FRAC_BITS (FracW)
  ) law_watch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .failures_o (failures),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  function automatic word_t fix(int whole);
    return word_t'(whole <<< FracW);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t pick_extreme();
    case ($urandom_range(0, 5))
      0:       return WordMax;
      1:       return WordMin;
      2:       return '0;
      3:       return '1;
      4:       return word_t'(1);
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:             return WordMax;
      1:             return WordMin;
      2:             return '0;
      3, 4, 5, 6:    return word_t'($urandom_range(0, 1 << 19) - (1 << 18));
      default:       return $urandom;
    endcase
  endfunction

  task automatic send_sample(input word_t tgt, input word_t meas, input logic rev);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= SampleW'({meas, tgt});
    s_axis_tuser  <= rev;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
  endtask

  // hold samples until every drive value is back, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input word_t vals [CfgCount]);
    for (int i = 0; i < CfgCount; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      writes_done++;
    end
    cfg_valid_i <= 1'b0;
    sets_run++;
  endtask

  // runs tracking around a setpoint, mixed at random with runs of raw noise and extreme corners
  task automatic run_random(input int unsigned count);
    int unsigned left, len, style;
    logic rev;
    int tgt, meas;
    left = count;
    while (left > 0) begin
      style  = $urandom_range(0, 9);
      len    = $urandom_range(3, 24);
      if (len > left) len = left;
      steady = ($urandom_range(0, 4) == 0);
      rev    = 1'($urandom_range(0, 1));
      tgt    = $urandom_range(0, 1 << 25) - (1 << 24);
      meas   = tgt + $urandom_range(0, 1 << 22) - (1 << 21);
      for (int unsigned i = 0; i < len; i++) begin
        if (style < 5) begin
          send_sample(tgt, meas, rev);
          meas = meas + $urandom_range(0, 1 << 18) - (1 << 17);
        end else if (style < 8) begin
          send_sample($urandom, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          send_sample(pick_extreme(), pick_extreme(), 1'($urandom_range(0, 1)));
        end
      end
      left -= len;
    end
  endtask

  initial begin
    int unsigned hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    word_t regs_next [CfgCount];
    word_t swap;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample('0, '0, 1'b0);
    send_sample(WordMax, WordMin, 1'b0);
    send_sample(WordMax, WordMin, 1'b1);
    send_sample(WordMin, WordMax, 1'b0);
    send_sample(WordMin, WordMax, 1'b1);
    send_sample('0, WordMax, 1'b0);
    send_sample('0, WordMin, 1'b1);
    send_sample('0, WordMax, 1'b1);
    repeat (3) send_sample(fix(200), fix(20), 1'b0);
    repeat (8) send_sample(WordMax, WordMin, 1'b0);
    repeat (3) send_sample(fix(-100), fix(20), 1'b0);
    sets_run++;
    run_random(RandomPerSet);

    for (int unsigned phase = 1; phase < SetCount; phase++) begin
      drain();
      case (phase)
        1: begin
          regs_next[CFG_GAIN_P]      = word_t'(98304);
          regs_next[CFG_GAIN_I_STEP] = word_t'(1024);
          regs_next[CFG_GAIN_D_STEP] = fix(1);
          regs_next[CFG_FILTER_POLE] = word_t'(32768);
          regs_next[CFG_OUT_FLOOR]   = fix(-100);
          regs_next[CFG_OUT_CEILING] = fix(100);
          regs_next[CFG_INT_FLOOR]   = fix(-50);
          regs_next[CFG_INT_CEILING] = fix(50);
        end
        2: begin
          regs_next[CFG_GAIN_P]      = WordMax;
          regs_next[CFG_GAIN_I_STEP] = WordMax;
          regs_next[CFG_GAIN_D_STEP] = WordMax;
          regs_next[CFG_FILTER_POLE] = WordMin;
          regs_next[CFG_OUT_FLOOR]   = WordMin;
          regs_next[CFG_OUT_CEILING] = WordMax;
          regs_next[CFG_INT_FLOOR]   = WordMin;
          regs_next[CFG_INT_CEILING] = WordMax;
        end
        3: begin
          regs_next[CFG_GAIN_P]      = WordMin;
          regs_next[CFG_GAIN_I_STEP] = WordMin;
          regs_next[CFG_GAIN_D_STEP] = WordMin;
          regs_next[CFG_FILTER_POLE] = WordMax;
          regs_next[CFG_OUT_FLOOR]   = fix(10);
          regs_next[CFG_OUT_CEILING] = fix(-10);
          regs_next[CFG_INT_FLOOR]   = fix(5);
          regs_next[CFG_INT_CEILING] = fix(-5);
        end
        4: begin
          for (int i = 0; i < CfgCount; i++) regs_next[i] = '0;
        end
        default: begin
          for (int i = 0; i < CfgCount; i++) regs_next[i] = rand_word();
          if ($urandom_range(0, 3) != 0 &&
              $signed(regs_next[CFG_OUT_FLOOR]) > $signed(regs_next[CFG_OUT_CEILING])) begin
            swap                       = regs_next[CFG_OUT_FLOOR];
            regs_next[CFG_OUT_FLOOR]   = regs_next[CFG_OUT_CEILING];
            regs_next[CFG_OUT_CEILING] = swap;
          end
          if ($urandom_range(0, 3) != 0 &&
              $signed(regs_next[CFG_INT_FLOOR]) > $signed(regs_next[CFG_INT_CEILING])) begin
            swap                       = regs_next[CFG_INT_FLOOR];
            regs_next[CFG_INT_FLOOR]   = regs_next[CFG_INT_CEILING];
            regs_next[CFG_INT_CEILING] = swap;
          end
        end
      endcase
      program_regs(regs_next);
      run_random(RandomPerSet);
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("%0d samples over %0d coefficient sets (%0d register writes),",
             samples_sent, sets_run, writes_done);
    $display("%0d drive values checked", checked);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pfd_pkg.sv
rtl/pfd_regs.sv
rtl/pfd_mulq.sv
rtl/pfd_core.sv
rtl/pid_filtered_derivative.sv
sim/pid_law_monitor.sv
sim/testbench.sv
